/* rtl/tty_pkg.sv */
// package for the teletype bus controller: command codes, item structs, constants
// no dependencies
`timescale 1ns / 1ps

package tty_pkg;

    typedef enum logic [2:0] {
        CMD_RESET      = 3'd0,
        CMD_STATUS     = 3'd1,
        CMD_DATAIN     = 3'd2,
        CMD_CTL_CLEAR  = 3'd3,
        CMD_CTL_SET    = 3'd4,
        CMD_DOUT_CLEAR = 3'd5,
        CMD_DOUT_SET   = 3'd6,
        CMD_RX_CHAR    = 3'd7
    } t_cmd;

    localparam logic [7:0] HIGH_BIT   = 8'o200;
    localparam logic [7:0] BYTE_MASK  = 8'o377;
    localparam logic [2:0] LEVEL_MASK = 3'd7;

    typedef struct packed {
        t_cmd        cmd;
        logic [10:0] bus_data;
        logic [7:0]  rx_char;
        logic        terminal_attached;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [6:0] tx_char;
        logic [2:0] interrupt_request;
    } t_out_item;

    // busy/done flags in status-word order
    typedef struct packed {
        logic in_busy;
        logic in_done;
        logic out_busy;
        logic out_done;
    } t_flags;

endpackage

/* rtl/tty_if.sv */
// valid/ready channel interfaces for the teletype bus controller
// depends on nothing
`timescale 1ns / 1ps

interface tty_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [10:0] bus_data;
    logic [7:0]  rx_char;
    logic        terminal_attached;

    modport source (output valid, cmd, bus_data, rx_char, terminal_attached, input ready);
    modport sink   (input valid, cmd, bus_data, rx_char, terminal_attached, output ready);
endinterface

interface tty_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic [2:0] interrupt_request;

    modport source (output valid, read_data, tx_valid, tx_char, interrupt_request, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_char, interrupt_request, output ready);
endinterface

/* rtl/teletype_io_bus_interface.sv */
// teletype bus controller top: input register, controller update, result register
// stages: the input register holds an accepted item, the result register its result
// throughput: one item per cycle unless o_out stalls; a taken result frees its register
// reset: synchronous active-low i_rst_n clears both stage valids and all controller state
// depends on tty_pkg, tty_if, tty_ctrl
`timescale 1ns / 1ps

module teletype_io_bus_interface (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tty_in_if.sink    i_in,
    tty_out_if.source o_out
);

    logic               r_in_valid;
    tty_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    tty_pkg::t_out_item r_out_item;
    tty_pkg::t_out_item w_result;
    logic               w_out_free;
    logic               w_step;
    logic               w_in_take;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item.cmd               <= tty_pkg::t_cmd'(i_in.cmd);
            r_in_item.bus_data          <= i_in.bus_data;
            r_in_item.rx_char           <= i_in.rx_char;
            r_in_item.terminal_attached <= i_in.terminal_attached;
        end
    end

    tty_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.read_data         = r_out_item.read_data;
    assign o_out.tx_valid          = r_out_item.tx_valid;
    assign o_out.tx_char           = r_out_item.tx_char;
    assign o_out.interrupt_request = r_out_item.interrupt_request;

    // input side only stalls when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");

    // an item in the input stage that advances shows up as a result
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out.valid)
        else $error("advanced item lost");

    // a transmitted character never comes with read data
    a_tx_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.tx_valid) |-> (o_out.read_data == 8'd0))
        else $error("read data on a transmit result");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_in_valid))
        else $error("stage valid after reset");

endmodule

/* rtl/tty_ctrl.sv */
// controller state (input character, flags, interrupt level) and the per-item update
// depends on tty_pkg
`timescale 1ns / 1ps

module tty_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tty_pkg::t_in_item  i_item,
    output tty_pkg::t_out_item o_result
);

    logic [7:0]      r_in_char, n_in_char;
    tty_pkg::t_flags r_flags, n_flags;
    logic [2:0]      r_irq_level, n_irq_level;

    always_comb begin
        n_in_char   = r_in_char;
        n_flags     = r_flags;
        n_irq_level = r_irq_level;
        o_result    = '0;
        case (i_item.cmd)
            tty_pkg::CMD_RESET: begin
                n_in_char   = '0;
                n_flags     = '0;
                n_irq_level = '0;
            end
            tty_pkg::CMD_STATUS: begin
                o_result.read_data = {1'b0, r_flags, r_irq_level & tty_pkg::LEVEL_MASK};
            end
            tty_pkg::CMD_DATAIN: begin
                o_result.read_data = r_in_char;
                n_flags.in_done    = 1'b0;
            end
            tty_pkg::CMD_CTL_CLEAR: begin
                n_irq_level = '0;
            end
            tty_pkg::CMD_CTL_SET: begin
                // clears first, then sets
                n_flags     = (r_flags & ~tty_pkg::t_flags'(i_item.bus_data[10:7]))
                            | tty_pkg::t_flags'(i_item.bus_data[6:3]);
                n_irq_level = r_irq_level | i_item.bus_data[2:0];
            end
            tty_pkg::CMD_DOUT_CLEAR: begin
                n_flags.out_busy = 1'b1;
                n_flags.out_done = 1'b0;
            end
            tty_pkg::CMD_DOUT_SET: begin
                if (i_item.terminal_attached) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_char  = i_item.bus_data[6:0];
                end
                n_flags.out_busy = 1'b0;
                n_flags.out_done = 1'b1;
            end
            tty_pkg::CMD_RX_CHAR: begin
                n_in_char       = i_item.rx_char | tty_pkg::HIGH_BIT;
                n_flags.in_busy = 1'b0;
                n_flags.in_done = 1'b1;
            end
            default: begin
                n_flags = r_flags;
            end
        endcase
        o_result.interrupt_request = (n_flags.out_done || n_flags.in_done) ? n_irq_level : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_char   <= '0;
            r_flags     <= '0;
            r_irq_level <= '0;
        end else if (i_step) begin
            r_in_char   <= n_in_char;
            r_flags     <= n_flags;
            r_irq_level <= n_irq_level;
        end
    end

endmodule

/* tb/sv/teletype_io_bus_interface_test.sv */
// self-checking testbench for the teletype bus controller: directed and random bus commands
// depends on tty_pkg, tty_if and the teletype_io_bus_interface rtl
`timescale 1ns / 1ps

module teletype_io_bus_interface_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int DRAIN_CYCLES  = 4;

    // shadow copy of the controller registers plus the queue of results still owed
    class tty_shadow;
        tty_pkg::t_out_item owed_results[$];
        int                 failures;
        logic [7:0]         out_char;
        logic [7:0]         in_char;
        tty_pkg::t_flags    flags;
        logic [2:0]         irq_level;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            out_char  = '0;
            in_char   = '0;
            flags     = '0;
            irq_level = '0;
        endfunction

        function tty_pkg::t_out_item predict_response(tty_pkg::t_in_item it);
            tty_pkg::t_out_item r;
            r = '0;
            case (it.cmd)
                tty_pkg::CMD_RESET: begin
                    clear_state();
                end
                tty_pkg::CMD_STATUS: begin
                    r.read_data = {1'b0, flags, irq_level};
                end
                tty_pkg::CMD_DATAIN: begin
                    r.read_data   = in_char;
                    flags.in_done = 1'b0;
                end
                tty_pkg::CMD_CTL_CLEAR: begin
                    irq_level = '0;
                end
                tty_pkg::CMD_CTL_SET: begin
                    // clears land before sets, level is or-ed in last
                    flags     = tty_pkg::t_flags'((flags & ~it.bus_data[10:7])
                                                  | it.bus_data[6:3]);
                    irq_level = (irq_level | it.bus_data[2:0]) & tty_pkg::LEVEL_MASK;
                end
                tty_pkg::CMD_DOUT_CLEAR: begin
                    out_char       = '0;
                    flags.out_busy = 1'b1;
                    flags.out_done = 1'b0;
                end
                tty_pkg::CMD_DOUT_SET: begin
                    out_char = it.bus_data[7:0];
                    if (it.terminal_attached) begin
                        out_char   = out_char & ~tty_pkg::HIGH_BIT;
                        r.tx_valid = 1'b1;
                        r.tx_char  = out_char[6:0];
                    end
                    flags.out_busy = 1'b0;
                    flags.out_done = 1'b1;
                end
                tty_pkg::CMD_RX_CHAR: begin
                    in_char       = it.rx_char | tty_pkg::HIGH_BIT;
                    flags.in_busy = 1'b0;
                    flags.in_done = 1'b1;
                end
            endcase
            r.interrupt_request = (flags.out_done || flags.in_done) ? irq_level : '0;
            return r;
        endfunction

        function void note_command(tty_pkg::t_in_item it);
            owed_results.push_back(predict_response(it));
        endfunction

        function void check_response(tty_pkg::t_out_item got);
            tty_pkg::t_out_item want;
            if (owed_results.size() == 0) begin
                $error("result arrived with no item pending");
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data expected %0h actual %0h", want.read_data, got.read_data);
                failures++;
            end
            if (got.tx_valid !== want.tx_valid) begin
                $error("tx_valid expected %0h actual %0h", want.tx_valid, got.tx_valid);
                failures++;
            end
            if (got.tx_char !== want.tx_char) begin
                $error("tx_char expected %0h actual %0h", want.tx_char, got.tx_char);
                failures++;
            end
            if (got.interrupt_request !== want.interrupt_request) begin
                $error("interrupt_request expected %0h actual %0h",
                       want.interrupt_request, got.interrupt_request);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    tty_shadow sb;

    tty_in_if  in_ch ();
    tty_out_if out_ch ();

    teletype_io_bus_interface dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver side: ready changes on the falling edge
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // handshakes sampled on the rising edge, watchdog on the same edge
    always @(posedge clk) begin
        tty_pkg::t_in_item  seen_cmd;
        tty_pkg::t_out_item seen_res;
        if (rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                seen_cmd.cmd               = tty_pkg::t_cmd'(in_ch.cmd);
                seen_cmd.bus_data          = in_ch.bus_data;
                seen_cmd.rx_char           = in_ch.rx_char;
                seen_cmd.terminal_attached = in_ch.terminal_attached;
                sb.note_command(seen_cmd);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                seen_res.read_data         = out_ch.read_data;
                seen_res.tx_valid          = out_ch.tx_valid;
                seen_res.tx_char           = out_ch.tx_char;
                seen_res.interrupt_request = out_ch.interrupt_request;
                sb.check_response(seen_res);
            end
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                    || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("teletype_io_bus_interface_test failed");
                $finish;
            end
        end
    end

    function automatic tty_pkg::t_in_item make_cmd(tty_pkg::t_cmd c, logic [10:0] bus,
                                                   logic [7:0] rx, logic att);
        tty_pkg::t_in_item it;
        it.cmd               = c;
        it.bus_data          = bus;
        it.rx_char           = rx;
        it.terminal_attached = att;
        return it;
    endfunction

    function automatic tty_pkg::t_in_item random_cmd();
        tty_pkg::t_cmd c;
        // bus resets kept rare so flag state can build up
        if ($urandom_range(0, 99) < 4)
            c = tty_pkg::CMD_RESET;
        else
            c = tty_pkg::t_cmd'($urandom_range(1, 7));
        return make_cmd(c, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endfunction

    // called on a falling edge, returns on the falling edge after the item is taken
    task automatic send_command(input tty_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.cmd               <= it.cmd;
        in_ch.bus_data          <= it.bus_data;
        in_ch.rx_char           <= it.rx_char;
        in_ch.terminal_attached <= it.terminal_attached;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_command(make_cmd(tty_pkg::CMD_RESET, 11'h7ff, 8'hff, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_RX_CHAR, 11'h7ff, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_DATAIN, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_RX_CHAR, 11'h000, 8'hff, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h7ff, 8'h55, 1'b1));
        // every clear and every set bit at once: sets win
        send_command(make_cmd(tty_pkg::CMD_CTL_SET, 11'h7ff, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_CTL_SET, 11'h780, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_CTL_SET, 11'h02d, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_CTL_CLEAR, 11'h7ff, 8'hff, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_DOUT_CLEAR, 11'h7ff, 8'hff, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_CTL_SET, 11'h007, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_DOUT_SET, 11'h0ff, 8'h00, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_DOUT_SET, 11'h0ff, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_DOUT_SET, 11'h700, 8'h00, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_DOUT_SET, 11'h77f, 8'h00, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_RX_CHAR, 11'h000, 8'h55, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_DATAIN, 11'h7ff, 8'haa, 1'b1));
        send_command(make_cmd(tty_pkg::CMD_DATAIN, 11'h000, 8'h00, 1'b0));
        send_command(make_cmd(tty_pkg::CMD_STATUS, 11'h000, 8'h00, 1'b0));
    endtask

    initial begin
        sb                      = new();
        quiet_cycles            = 0;
        send_idle_pct           = 30;
        recv_idle_pct           = 47;
        rst_n                   = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.cmd               = tty_pkg::CMD_RESET;
        in_ch.bus_data          = '0;
        in_ch.rx_char           = '0;
        in_ch.terminal_attached = 1'b0;
        out_ch.ready            = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                send_command(random_cmd());
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.owed_results.size() != 0) begin
            $error("%0d results never arrived", sb.owed_results.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("teletype_io_bus_interface_test passed");
        end else begin
            $display("teletype_io_bus_interface_test failed");
        end
        $finish;
    end

endmodule
